FILE: hw/rtl/rsbn_pkg.sv
// ----------------------------------------------------------------------------
// rsbn_pkg
// Types and constants for the record sorter: capacity, record layout and
// the sequencer states.
// ----------------------------------------------------------------------------
package rsbn_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NAME_WORDS  = 7;
    localparam int WORD_W      = 64;
    localparam int ID_W        = 16;
    localparam int GRADE_W     = 4;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    // name word 0 sits in the top slot, so the packed name compares as one
    // unsigned number in the right order
    typedef struct packed {
        logic [NAME_WORDS-1:0][WORD_W-1:0] name;
        logic [ID_W-1:0]                   id;
        logic [GRADE_W-1:0]                grade;
    } t_record;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_LD_I,
        S_CMP,
        S_WB,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

endpackage

FILE: hw/rtl/record_sort_by_name_core.sv
// ----------------------------------------------------------------------------
// record_sort_by_name_core
// Collects records into a one-entry-per-record RAM, exchange-sorts them by
// name (highest first) in place, then streams them out in order.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one record per transfer. Records
// are written in arrival order; once MAX_RECORDS are held, further records
// are dropped. A transfer with i_in_last set ends the set and starts the sort.
// o_in_ready is high only while loading.
// Sort: record i is held in a register while records j > i are read from the
// RAM one per cycle; a larger name swaps with the held record (the held one
// is written back to slot j). At the end of a pass the held record goes to
// slot i. The registered RAM read sets the pace of the sort.
// Output channel (o_out_valid / i_out_ready): results come from an output
// register; each record is first read from the RAM and then loaded into the
// register. The receiver may stall indefinitely; the block simply waits.
// o_out_last marks the final sorted record; after its transfer the block is
// empty and loading resumes. n records give min(n, MAX_RECORDS) results,
// only after the last one. Reset (i_rst_n low, synchronous) empties the block.
// ----------------------------------------------------------------------------
module record_sort_by_name_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_0,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_1,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_2,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_3,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_4,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_5,
    input  logic [rsbn_pkg::WORD_W-1:0]  i_in_name_6,
    input  logic [rsbn_pkg::ID_W-1:0]    i_in_student_id,
    input  logic [rsbn_pkg::GRADE_W-1:0] i_in_grade,
    input  logic                      i_in_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_0,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_1,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_2,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_3,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_4,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_5,
    output logic [rsbn_pkg::WORD_W-1:0]  o_out_name_6,
    output logic [rsbn_pkg::ID_W-1:0]    o_out_student_id,
    output logic [rsbn_pkg::GRADE_W-1:0] o_out_grade,
    output logic                      o_out_last
);
    import rsbn_pkg::*;

    t_record r_mem [MAX_RECORDS];
    t_record r_rd;

    t_state     r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    t_record    r_held, n_held;
    t_record    r_out, n_out;
    logic       r_out_valid, n_out_valid;
    logic       r_out_last, n_out_last;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_record    wr_data;
    logic       wr_en;
    t_record    in_rec;
    logic       in_xfer;
    logic       full;
    logic [CNT_W-1:0] cnt_after;

    // word 0 goes to the top slot so it leads the compare
    assign in_rec.name  = {i_in_name_0, i_in_name_1, i_in_name_2, i_in_name_3,
                           i_in_name_4, i_in_name_5, i_in_name_6};
    assign in_rec.id    = i_in_student_id;
    assign in_rec.grade = i_in_grade;

    assign o_in_ready = (r_state == S_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(MAX_RECORDS));
    assign cnt_after  = full ? r_count : r_count + CNT_W'(1);

    // record RAM: one write and one read port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
        r_held     <= n_held;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_held      = r_held;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        rd_addr     = '0;
        wr_addr     = '0;
        wr_data     = r_held;
        wr_en       = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                wr_addr = r_count[IDX_W-1:0];
                wr_data = in_rec;
                if (in_xfer) begin
                    wr_en   = !full;
                    n_count = cnt_after;
                    if (i_in_last) begin
                        n_i = '0;
                        n_k = '0;
                        n_state = (cnt_after < CNT_W'(2)) ? S_EMIT_RD : S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                rd_addr = r_i;
                n_j     = r_i + IDX_W'(1);
                n_state = S_LD_I;
            end
            S_LD_I: begin
                n_held  = r_rd;
                rd_addr = r_j;
                n_state = S_CMP;
            end
            S_CMP: begin
                // r_rd holds record j; larger name moves up into the held slot
                if (r_held.name < r_rd.name) begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = r_held;
                    n_held  = r_rd;
                end
                if (CNT_W'(r_j) + CNT_W'(1) == r_count) begin
                    n_state = S_WB;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    rd_addr = r_j + IDX_W'(1);
                end
            end
            S_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_held;
                if (CNT_W'(r_i) + CNT_W'(2) == r_count) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    // next pass: fetch record i+1 while slot i is written
                    n_i     = r_i + IDX_W'(1);
                    n_j     = r_i + IDX_W'(2);
                    rd_addr = r_i + IDX_W'(1);
                    n_state = S_LD_I;
                end
            end
            S_EMIT_RD: begin
                rd_addr = r_k;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out       = r_rd;
                n_out_valid = 1'b1;
                n_out_last  = (CNT_W'(r_k) + CNT_W'(1) == r_count);
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        rd_addr = r_k + IDX_W'(1);
                        n_state = S_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_name_0     = r_out.name[NAME_WORDS-1];
    assign o_out_name_1     = r_out.name[NAME_WORDS-2];
    assign o_out_name_2     = r_out.name[NAME_WORDS-3];
    assign o_out_name_3     = r_out.name[NAME_WORDS-4];
    assign o_out_name_4     = r_out.name[NAME_WORDS-5];
    assign o_out_name_5     = r_out.name[NAME_WORDS-6];
    assign o_out_name_6     = r_out.name[NAME_WORDS-7];
    assign o_out_student_id = r_out.id;
    assign o_out_grade      = r_out.grade;
    assign o_out_last       = r_out_last;

endmodule

FILE: test/record_sort_by_name_core_test.sv
// ----------------------------------------------------------------------------
// record_sort_by_name_core_test
// Self-checking bench for the record sorter. Record sets of 1 to 67 entries
// (overflow past capacity included) go in through the input channel; an
// in-bench exchange-sort predictor builds the sorted set on each final
// record, and every output transfer is checked against it field by field.
// Both channels see random idle bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module record_sort_by_name_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rsbn_pkg::*;

    localparam int NAME_BITS   = NAME_WORDS * WORD_W;
    localparam int ITEM_TARGET = 410;
    localparam int QUIET_TAIL  = 40;    // no idling once fewer records than this remain
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 40;

    typedef logic [NAME_BITS-1:0] name_key_t;

    typedef struct {
        t_record rec;
        logic    last;
        bit      drain;     // hold back until every sorted record has left
    } record_item_t;

    typedef struct packed {
        t_record rec;
        logic    last;
    } sorted_rec_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [WORD_W-1:0]   in_name_0 = '0, in_name_1 = '0, in_name_2 = '0, in_name_3 = '0;
    logic [WORD_W-1:0]   in_name_4 = '0, in_name_5 = '0, in_name_6 = '0;
    logic [ID_W-1:0]     in_student_id = '0;
    logic [GRADE_W-1:0]  in_grade = '0;
    logic                in_last = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [WORD_W-1:0]   out_name_0, out_name_1, out_name_2, out_name_3;
    logic [WORD_W-1:0]   out_name_4, out_name_5, out_name_6;
    logic [ID_W-1:0]     out_student_id;
    logic [GRADE_W-1:0]  out_grade;
    logic                out_last;

    record_item_t  pending_records[$];
    sorted_rec_t   sorted_q[$];
    name_key_t     name_pool[$];
    t_record       held[MAX_RECORDS];
    int            held_cnt = 0;
    record_item_t  in_cur;
    logic          in_xfer = 1'b0;
    int            in_gap = 0;
    int            out_gap = 0;
    bit            in_idle_mode = 1'b1;
    bit            out_idle_mode = 1'b1;
    int            mismatches = 0;

    record_sort_by_name_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_name_0      (in_name_0),
        .i_in_name_1      (in_name_1),
        .i_in_name_2      (in_name_2),
        .i_in_name_3      (in_name_3),
        .i_in_name_4      (in_name_4),
        .i_in_name_5      (in_name_5),
        .i_in_name_6      (in_name_6),
        .i_in_student_id  (in_student_id),
        .i_in_grade       (in_grade),
        .i_in_last        (in_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_name_0     (out_name_0),
        .o_out_name_1     (out_name_1),
        .o_out_name_2     (out_name_2),
        .o_out_name_3     (out_name_3),
        .o_out_name_4     (out_name_4),
        .o_out_name_5     (out_name_5),
        .o_out_name_6     (out_name_6),
        .o_out_student_id (out_student_id),
        .o_out_grade      (out_grade),
        .o_out_last       (out_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_record(input name_key_t key, input logic [ID_W-1:0] id,
                              input logic [GRADE_W-1:0] grade, input logic last,
                              input bit drain);
        record_item_t it;
        it.rec.name  = key;
        it.rec.id    = id;
        it.rec.grade = grade;
        it.last      = last;
        it.drain     = drain;
        pending_records.push_back(it);
    endtask

    // first character lands in the top byte of name word 0
    function automatic name_key_t text_name(input string s);
        name_key_t key;
        key = '0;
        for (int b = 0; b < s.len() && b < NAME_BITS / 8; b++)
            key[NAME_BITS-1-8*b -: 8] = s[b];
        return key;
    endfunction

    // mix of random keys, short strings over a tiny alphabet, exact repeats
    // and near repeats, so compares often run deep into the later words
    function automatic name_key_t make_name();
        name_key_t key;
        int        pick;
        int        len;
        pick = $urandom_range(0, 9);
        if (pick < 3 || name_pool.size() == 0) begin
            for (int w = 0; w < NAME_BITS / 32; w++)
                key[32*w +: 32] = $urandom();
        end else if (pick < 6) begin
            key = '0;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NAME_BITS / 8)
                                              : $urandom_range(1, 6);
            for (int b = 0; b < len; b++)
                key[NAME_BITS-1-8*b -: 8] = 8'h41 + 8'($urandom_range(0, 3));
        end else begin
            key = name_pool[$urandom_range(0, name_pool.size() - 1)];
            if (pick >= 8)
                key[8*$urandom_range(0, NAME_BITS / 8 - 1) +: 8] = 8'($urandom_range(0, 255));
        end
        name_pool.push_back(key);
        if (name_pool.size() > 16)
            void'(name_pool.pop_front());
        return key;
    endfunction

    // ------------------------------------------------------------------
    // predictor: collect, exchange-sort descending on the final record
    // ------------------------------------------------------------------
    task automatic take_record(input t_record r, input logic last);
        t_record     tmp;
        sorted_rec_t s;
        if (held_cnt < MAX_RECORDS) begin
            held[held_cnt] = r;
            held_cnt++;
        end
        if (last) begin
            for (int i = 0; i + 1 < held_cnt; i++)
                for (int j = i + 1; j < held_cnt; j++)
                    if (name_key_t'(held[i].name) < name_key_t'(held[j].name)) begin
                        tmp     = held[i];
                        held[i] = held[j];
                        held[j] = tmp;
                    end
            for (int i = 0; i < held_cnt; i++) begin
                s.rec  = held[i];
                s.last = (i == held_cnt - 1);
                sorted_q.push_back(s);
            end
            held_cnt = 0;
        end
    endtask

    task automatic note_field(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // record driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_records
        logic v;
        v = i_in_valid;
        if (in_xfer)
            v = 1'b0;
        if ($urandom_range(0, 199) == 0)
            in_idle_mode = !in_idle_mode;
        if (i_rst_n && !v) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_records.size() != 0
                         && !(pending_records[0].drain && sorted_q.size() != 0)) begin
                if (in_idle_mode && pending_records.size() >= QUIET_TAIL
                    && $urandom_range(0, 3) == 0) begin
                    in_gap = $urandom_range(0, 5);
                end else begin
                    in_cur = pending_records.pop_front();
                    v = 1'b1;
                    {in_name_0, in_name_1, in_name_2, in_name_3,
                     in_name_4, in_name_5, in_name_6} <= in_cur.rec.name;
                    in_student_id <= in_cur.rec.id;
                    in_grade      <= in_cur.rec.grade;
                    in_last       <= in_cur.last;
                end
            end
        end
        i_in_valid <= v;
    end

    always @(negedge i_clk) begin : drive_out_ready
        logic r;
        if ($urandom_range(0, 199) == 0)
            out_idle_mode = !out_idle_mode;
        if (out_gap > 0) begin
            out_gap--;
            r = 1'b0;
        end else if (out_idle_mode && pending_records.size() >= QUIET_TAIL
                     && $urandom_range(0, 3) == 0) begin
            out_gap = $urandom_range(0, 5);
            r = 1'b0;
        end else begin
            r = 1'b1;
        end
        i_out_ready <= r;
    end

    // ------------------------------------------------------------------
    // monitor: predict on input transfers, check output transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_transfers
        t_record     got;
        sorted_rec_t want;
        in_xfer <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            take_record(in_cur.rec, in_cur.last);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.name  = {out_name_0, out_name_1, out_name_2, out_name_3,
                         out_name_4, out_name_5, out_name_6};
            got.id    = out_student_id;
            got.grade = out_grade;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output record: id %h grade %h last %b",
                             got.id, got.grade, out_last);
            end else begin
                want = sorted_q.pop_front();
                for (int k = 0; k < NAME_WORDS; k++)
                    note_field($sformatf("name_%0d", k), want.rec.name[NAME_WORDS-1-k],
                               got.name[NAME_WORDS-1-k]);
                note_field("student_id", 64'(want.rec.id), 64'(got.id));
                note_field("grade", 64'(want.rec.grade), 64'(got.grade));
                note_field("last", 64'(want.last), 64'(out_last));
            end
        end
    end

    initial begin : watchdog
        for (int c = 0; c < CYCLE_LIMIT; c++)
            @(posedge i_clk);
        $display("record_sort_by_name_core_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : run
        name_key_t k1;
        name_key_t k2;
        int        total;
        int        set_idx;
        int        set_size;

        // single-record sets at the field extremes
        add_record('0, '0, '0, 1'b1, 1'b0);
        add_record('1, '1, '1, 1'b1, 1'b0);
        // two records that must swap
        add_record(text_name("ALICE"), 16'd1, 4'd3, 1'b0, 1'b0);
        add_record(text_name("BOB"), 16'd2, 4'd7, 1'b1, 1'b0);
        // equal names never swap; also wait for the previous set to drain
        add_record(text_name("SAME"), 16'd10, 4'd1, 1'b0, 1'b1);
        add_record(text_name("SAME"), 16'd11, 4'd2, 1'b0, 1'b0);
        add_record(text_name("SAME"), 16'd12, 4'd3, 1'b1, 1'b0);
        // bytes after the terminator still count; differences only in late words
        k1 = text_name("AB");
        k2 = k1;
        k2[7:0] = 8'h01;
        add_record(k1, 16'h0100, 4'd4, 1'b0, 1'b0);
        add_record(k2, 16'h0101, 4'd5, 1'b0, 1'b0);
        k2 = k1;
        k2[8*30 +: 8] = 8'h7f;
        add_record(k2, 16'h0102, 4'd6, 1'b0, 1'b0);
        k2 = '1;
        k2[WORD_W-1:0] = '0;
        add_record(k2, 16'h0103, 4'd8, 1'b0, 1'b0);
        add_record('1, 16'h0104, 4'd9, 1'b1, 1'b0);
        // already descending, with a tie
        add_record(text_name("ZED"), 16'h0200, 4'd0, 1'b0, 1'b0);
        add_record(text_name("YAK"), 16'h0201, 4'd1, 1'b0, 1'b0);
        add_record(text_name("XAVIER"), 16'h0202, 4'd2, 1'b0, 1'b0);
        add_record(text_name("MOE"), 16'h0203, 4'd3, 1'b0, 1'b0);
        add_record(text_name("MOE"), 16'h0204, 4'd4, 1'b0, 1'b0);
        add_record(text_name("A"), 16'h0205, 4'd15, 1'b1, 1'b0);

        // random sets: mostly small, one exactly full, one overflowing
        total   = pending_records.size();
        set_idx = 0;
        while (total < ITEM_TARGET) begin
            if (set_idx == 4)
                set_size = MAX_RECORDS;
            else if (set_idx == 11)
                set_size = MAX_RECORDS + 3;
            else if ($urandom_range(0, 7) == 0)
                set_size = 1;
            else
                set_size = $urandom_range(2, 12);
            for (int r = 0; r < set_size; r++)
                add_record(make_name(), 16'($urandom_range(0, 65535)),
                           4'($urandom_range(0, 15)), r == set_size - 1,
                           r == 0 && set_idx % 6 == 2);
            total += set_size;
            set_idx++;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_records.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (sorted_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("record_sort_by_name_core_test passed");
        else
            $display("record_sort_by_name_core_test failed");
        $finish;
    end

endmodule

FILE: record_sort_by_name_core.f
hw/rtl/rsbn_pkg.sv
hw/rtl/record_sort_by_name_core.sv
test/record_sort_by_name_core_test.sv
